// ----- design/prg_pkg.sv -----
// ----------------------------------------------------------------------------
// prg_pkg
// shared constants and types for the polypurine run grouper
// ----------------------------------------------------------------------------
`default_nettype none

package prg_pkg;

    localparam int MAX_RADIUS = 1024;

    localparam int POS_W   = 11;
    localparam int REG_W   = 11;
    localparam int FRAC_W  = 16;
    localparam int SCORE_W = FRAC_W + 1;
    localparam int SQ_W    = 2 * REG_W;

    // decoded state codes
    localparam logic [1:0] ST_PPT  = 2'd0;
    localparam logic [1:0] ST_BG   = 2'd1;
    localparam logic [1:0] ST_UBOX = 2'd2;
    localparam logic [1:0] ST_UNK  = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PPT_LEN_MIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PPT_LEN_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UBOX_LEN_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UBOX_LEN_MAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_UBOX_DIST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE       = 3'd6;

    // configuration reset values
    localparam logic [REG_W-1:0] RST_RADIUS        = 11'd30;
    localparam logic [REG_W-1:0] RST_PPT_LEN_MIN   = 11'd5;
    localparam logic [REG_W-1:0] RST_PPT_LEN_MAX   = 11'd15;
    localparam logic [REG_W-1:0] RST_UBOX_LEN_MIN  = 11'd2;
    localparam logic [REG_W-1:0] RST_UBOX_LEN_MAX  = 11'd15;
    localparam logic [REG_W-1:0] RST_MAX_UBOX_DIST = 11'd0;

    // request to the score unit
    typedef struct packed {
        logic             start;
        logic [REG_W-1:0] radius;
        logic [POS_W-1:0] run_end;
    } t_score_req;

    // answer from the score unit
    typedef struct packed {
        logic               done;
        logic [SCORE_W-1:0] score;
    } t_score_rsp;

endpackage

`default_nettype wire

// ----- design/prg_score.sv -----
// ----------------------------------------------------------------------------
// prg_score
// iterative score unit: one shared multiplier squares radius and distance,
// then a restoring divider yields one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module prg_score (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  prg_pkg::t_score_req i_req,
    output prg_pkg::t_score_rsp o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQR  = 3'd1;
    localparam logic [2:0] S_SQD  = 3'd2;
    localparam logic [2:0] S_SUB  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;

    localparam int CNT_W = $clog2(prg_pkg::SCORE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(prg_pkg::SCORE_W - 1);

    logic [2:0]                    r_state, n_state;
    logic [prg_pkg::REG_W-1:0]     r_rad;
    logic [prg_pkg::REG_W-1:0]     r_dist;
    logic [prg_pkg::SQ_W-1:0]      r_r2;
    logic [prg_pkg::SQ_W:0]        r_rem;
    logic [prg_pkg::SCORE_W-1:0]   r_quot;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_done;

    logic [prg_pkg::REG_W-1:0]     dist_in;
    logic [prg_pkg::REG_W-1:0]     mul_a;
    logic [prg_pkg::SQ_W-1:0]      prod;
    logic                          ge;
    logic [prg_pkg::SQ_W:0]        diff;

    // distance of the run end from position radius, one past the window centre
    always_comb begin
        if (i_req.run_end > i_req.radius) begin
            dist_in = i_req.run_end - i_req.radius;
        end else begin
            dist_in = i_req.radius - i_req.run_end;
        end
    end

    // shared multiplier
    assign mul_a = (r_state == S_SQR) ? r_rad : r_dist;
    assign prod  = mul_a * mul_a;

    // divider step
    assign ge   = (r_rem >= {1'b0, r_r2});
    assign diff = ge ? (r_rem - {1'b0, r_r2}) : r_rem;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.start) n_state = S_SQR;
            end
            S_SQR: n_state = S_SQD;
            S_SQD: n_state = S_SUB;
            S_SUB: n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == CNT_LAST) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_DIV) && (r_cnt == CNT_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_rad  <= i_req.radius;
                r_dist <= dist_in;
            end
            S_SQR: r_r2 <= prod;
            S_SQD: r_rem <= {1'b0, prod};
            S_SUB: begin
                r_rem  <= (r_rem <= {1'b0, r_r2}) ? ({1'b0, r_r2} - r_rem) : '0;
                r_cnt  <= '0;
                r_quot <= '0;
            end
            S_DIV: begin
                r_quot <= {r_quot[prg_pkg::SCORE_W-2:0], ge};
                r_rem  <= {diff[prg_pkg::SQ_W-1:0], 1'b0};
                r_cnt  <= r_cnt + 1'b1;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.score = r_quot;

endmodule

`default_nettype wire

// ----- design/ppt_run_grouper.sv -----
// ----------------------------------------------------------------------------
// ppt_run_grouper
// groups decoded model states into runs and reports accepted polypurine runs
// ----------------------------------------------------------------------------
// One decoded state is taken per transfer. A state that closes no accepted
// polypurine run is absorbed without stalling input. A state that closes one
// starts the score unit: the shared multiplier squares radius and then
// distance, a further step forms the numerator, and the divider gives one of
// the 17 quotient bits per cycle, after which the hit is offered. Input stays
// stalled from that transfer until the hit has been taken downstream.
`default_nettype none

module ppt_run_grouper (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire  [1:0]                        i_state_code,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [prg_pkg::POS_W-1:0]         o_ppt_start,
    output logic [prg_pkg::POS_W-1:0]         o_ppt_end,
    output logic [prg_pkg::SCORE_W-1:0]       o_score,
    output logic                              o_has_ubox,
    output logic [prg_pkg::POS_W-1:0]         o_ubox_start,
    output logic [prg_pkg::POS_W-1:0]         o_ubox_end,
    output logic                              o_strand_tag,
    input  wire                               i_cfg_we,
    input  wire  [prg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [prg_pkg::REG_W-1:0]         i_cfg_data
);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_BUSY = 2'd1;
    localparam logic [1:0] T_HOLD = 2'd2;

    localparam int PW = prg_pkg::POS_W;
    localparam int RW = prg_pkg::REG_W;

    typedef struct packed {
        logic          valid;
        logic [PW-1:0] start;
        logic [PW-1:0] stop;
    } t_pend;

    typedef struct packed {
        t_pend pend;
        logic  hit;
        logic  pair;
    } t_close;

    // configuration
    logic [RW-1:0] r_radius, r_ppt_min, r_ppt_max, r_ubox_min, r_ubox_max, r_dist;
    logic          r_reverse;

    // run tracking
    logic [1:0]    r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic [1:0]    r_prev;
    logic [PW-1:0] r_run_start, n_run_start;
    t_pend         r_pend, n_pend;

    // held result
    logic [PW-1:0]               r_out_ppt_start, r_out_ppt_end;
    logic [PW-1:0]               r_out_ubox_start, r_out_ubox_end;
    logic                        r_out_has_ubox, r_out_strand;
    logic [prg_pkg::SCORE_W-1:0] r_out_score;

    logic                 accept;
    logic [RW-1:0]        rad_eff;
    logic [PW:0]          last;
    logic [PW-1:0]        p;
    logic                 c1, is_last, hit1, hit2, hit;
    t_close               cl1, cl2;
    t_pend                pend1;
    logic [PW-1:0]        rs1;
    logic [PW-1:0]        hit_s, hit_e, hit_us, hit_ue;
    logic                 hit_pair;
    prg_pkg::t_score_req  score_req;
    prg_pkg::t_score_rsp  score_rsp;

    function automatic t_close close_run(
        input logic [1:0]    st,
        input logic [PW-1:0] s,
        input logic [PW-1:0] e,
        input t_pend         pin,
        input logic [RW-1:0] p_min,
        input logic [RW-1:0] p_max,
        input logic [RW-1:0] u_min,
        input logic [RW-1:0] u_max,
        input logic [RW-1:0] gap_max
    );
        logic [PW:0] len;
        logic [PW:0] gap;
        t_close      res;
        len      = {1'b0, e} - {1'b0, s} + 1'b1;
        gap      = {1'b0, s} - {1'b0, pin.stop};
        res.pend = pin;
        res.hit  = 1'b0;
        res.pair = 1'b0;
        if (st == prg_pkg::ST_UBOX) begin
            if (len >= {1'b0, u_min} && len <= {1'b0, u_max}) begin
                res.pend.valid = 1'b1;
                res.pend.start = s;
                res.pend.stop  = e;
            end
        end else begin
            if (st == prg_pkg::ST_PPT && len >= {1'b0, p_min} && len <= {1'b0, p_max}) begin
                res.hit  = 1'b1;
                res.pair = pin.valid && (gap <= {1'b0, gap_max});
            end
            res.pend = '0;
        end
        return res;
    endfunction

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != T_IDLE);

    // effective radius and window end
    always_comb begin
        if (r_radius == '0) begin
            rad_eff = RW'(1);
        end else if (32'(r_radius) > prg_pkg::MAX_RADIUS) begin
            rad_eff = RW'(prg_pkg::MAX_RADIUS);
        end else begin
            rad_eff = r_radius;
        end
    end

    assign last = {rad_eff, 1'b0} - (PW+1)'(2);
    assign p    = ({1'b0, r_pos} > last) ? last[PW-1:0] : r_pos;

    always_comb begin
        c1      = (p != '0) && (i_state_code != r_prev);
        cl1     = close_run(r_prev, r_run_start, p - 1'b1, r_pend,
                            r_ppt_min, r_ppt_max, r_ubox_min, r_ubox_max, r_dist);
        pend1   = c1 ? cl1.pend : r_pend;
        if (p == '0) begin
            rs1 = '0;
        end else if (c1) begin
            rs1 = p;
        end else begin
            rs1 = r_run_start;
        end
        is_last = ({1'b0, p} == last);
        cl2     = close_run(i_state_code, rs1, p, pend1,
                            r_ppt_min, r_ppt_max, r_ubox_min, r_ubox_max, r_dist);
        hit1    = c1 && cl1.hit;
        hit2    = is_last && cl2.hit;
        hit     = hit1 || hit2;

        if (hit1) begin
            hit_s    = r_run_start;
            hit_e    = p - 1'b1;
            hit_pair = cl1.pair;
            hit_us   = cl1.pair ? r_pend.start : '0;
            hit_ue   = cl1.pair ? r_pend.stop : '0;
        end else begin
            hit_s    = rs1;
            hit_e    = p;
            hit_pair = cl2.pair;
            hit_us   = cl2.pair ? pend1.start : '0;
            hit_ue   = cl2.pair ? pend1.stop : '0;
        end

        n_run_start = rs1;
        n_pend      = is_last ? '0 : pend1;
        n_pos       = is_last ? '0 : p + 1'b1;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE: begin
                if (accept && hit) n_state = T_BUSY;
            end
            T_BUSY: begin
                if (score_rsp.done) n_state = T_HOLD;
            end
            T_HOLD: begin
                if (!i_out_stall) n_state = T_IDLE;
            end
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_pos       <= '0;
            r_prev      <= prg_pkg::ST_PPT;
            r_run_start <= '0;
            r_pend      <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_pos       <= n_pos;
                r_prev      <= i_state_code;
                r_run_start <= n_run_start;
                r_pend      <= n_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius   <= prg_pkg::RST_RADIUS;
            r_ppt_min  <= prg_pkg::RST_PPT_LEN_MIN;
            r_ppt_max  <= prg_pkg::RST_PPT_LEN_MAX;
            r_ubox_min <= prg_pkg::RST_UBOX_LEN_MIN;
            r_ubox_max <= prg_pkg::RST_UBOX_LEN_MAX;
            r_dist     <= prg_pkg::RST_MAX_UBOX_DIST;
            r_reverse  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                prg_pkg::CFG_RADIUS:        r_radius   <= i_cfg_data;
                prg_pkg::CFG_PPT_LEN_MIN:   r_ppt_min  <= i_cfg_data;
                prg_pkg::CFG_PPT_LEN_MAX:   r_ppt_max  <= i_cfg_data;
                prg_pkg::CFG_UBOX_LEN_MIN:  r_ubox_min <= i_cfg_data;
                prg_pkg::CFG_UBOX_LEN_MAX:  r_ubox_max <= i_cfg_data;
                prg_pkg::CFG_MAX_UBOX_DIST: r_dist     <= i_cfg_data;
                prg_pkg::CFG_REVERSE:       r_reverse  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept && hit) begin
            r_out_ppt_start  <= hit_s;
            r_out_ppt_end    <= hit_e;
            r_out_has_ubox   <= hit_pair;
            r_out_ubox_start <= hit_us;
            r_out_ubox_end   <= hit_ue;
            r_out_strand     <= r_reverse;
        end
        if (r_state == T_BUSY && score_rsp.done) begin
            r_out_score <= score_rsp.score;
        end
    end

    assign score_req.start   = accept && hit;
    assign score_req.radius  = rad_eff;
    assign score_req.run_end = hit_e;

    prg_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (score_req),
        .o_rsp   (score_rsp)
    );

    assign o_out_valid  = (r_state == T_HOLD);
    assign o_ppt_start  = r_out_ppt_start;
    assign o_ppt_end    = r_out_ppt_end;
    assign o_score      = r_out_score;
    assign o_has_ubox   = r_out_has_ubox;
    assign o_ubox_start = r_out_ubox_start;
    assign o_ubox_end   = r_out_ubox_end;
    assign o_strand_tag = r_out_strand;

endmodule

`default_nettype wire

// ----- design/prg_chk.sv -----
// ----------------------------------------------------------------------------
// prg_chk
// port-level checks on the run grouper, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module prg_chk (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_in_valid,
    input wire                           o_in_stall,
    input wire                           o_out_valid,
    input wire                           i_out_stall,
    input wire [prg_pkg::POS_W-1:0]      o_ppt_start,
    input wire [prg_pkg::POS_W-1:0]      o_ppt_end,
    input wire [prg_pkg::SCORE_W-1:0]    o_score,
    input wire                           o_has_ubox,
    input wire [prg_pkg::POS_W-1:0]      o_ubox_start,
    input wire [prg_pkg::POS_W-1:0]      o_ubox_end
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_score)
            && $stable(o_ppt_start) && $stable(o_ppt_end)))
        else $error("result changed while stalled");

    // no new transfer in while a hit waits downstream
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    // only one result per hit
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> !o_out_valid)
        else $error("result repeated");

    // unpaired hit carries no u-box position
    a_no_ubox: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_ubox) |-> (o_ubox_start == '0 && o_ubox_end == '0))
        else $error("u-box position on unpaired hit");

    // run order and score range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_ppt_start <= o_ppt_end
            && o_score <= prg_pkg::SCORE_W'(1 << prg_pkg::FRAC_W)))
        else $error("result out of range");

endmodule

bind ppt_run_grouper prg_chk u_prg_chk (.*);

`default_nettype wire

// ----- sim/ppt_hit_checker.sv -----
// ----------------------------------------------------------------------------
// ppt_hit_checker
// watches the run grouper's ports, predicts every PPT hit from the accepted
// decoded states and the register writes, and compares each hit transfer
// field by field with the oldest prediction
// ----------------------------------------------------------------------------

module ppt_hit_checker
    import prg_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_stall,
    input  wire  [1:0]           i_state_code,
    input  wire                  i_out_valid,
    input  wire                  i_out_stall,
    input  wire  [POS_W-1:0]     i_ppt_start,
    input  wire  [POS_W-1:0]     i_ppt_end,
    input  wire  [SCORE_W-1:0]   i_score,
    input  wire                  i_has_ubox,
    input  wire  [POS_W-1:0]     i_ubox_start,
    input  wire  [POS_W-1:0]     i_ubox_end,
    input  wire                  i_strand_tag,
    input  wire                  i_cfg_we,
    input  wire  [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [REG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_hit_count,
    output int                   o_paired_count
);

    typedef struct packed {
        logic [POS_W-1:0]   ppt_start;
        logic [POS_W-1:0]   ppt_end;
        logic [SCORE_W-1:0] score;
        logic               has_ubox;
        logic [POS_W-1:0]   ubox_start;
        logic [POS_W-1:0]   ubox_end;
        logic               strand_tag;
    } ppt_hit_t;

    logic [REG_W-1:0] radius_reg;
    logic [REG_W-1:0] ppt_min;
    logic [REG_W-1:0] ppt_max;
    logic [REG_W-1:0] ubox_min;
    logic [REG_W-1:0] ubox_max;
    logic [REG_W-1:0] ubox_dist;
    logic             reverse_reg;

    logic [31:0] window_pos;
    logic [31:0] run_start;
    logic [1:0]  prev_code;
    logic        ubox_held;
    logic [31:0] held_start;
    logic [31:0] held_end;

    ppt_hit_t expected_hits [$];
    int fails;
    int hits;
    int paired;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    task automatic drop_ubox();
        ubox_held  = 1'b0;
        held_start = '0;
        held_end   = '0;
    endtask

    // a run of one state has ended at position e
    task automatic close_run(input logic [1:0] code, input logic [31:0] s,
                             input logic [31:0] e, input logic [31:0] r,
                             inout bit emitted);
        logic [31:0]     len;
        longint unsigned r2;
        longint unsigned d;
        longint unsigned num;
        longint unsigned quot;
        logic            pair;
        ppt_hit_t        hit;
        len = e - s + 32'd1;
        if (code == ST_UBOX) begin
            if (len >= ubox_min && len <= ubox_max) begin
                ubox_held  = 1'b1;
                held_start = s;
                held_end   = e;
            end
            return;
        end
        if (code == ST_PPT && len >= ppt_min && len <= ppt_max) begin
            r2   = longint'(r) * longint'(r);
            d    = (e > r) ? longint'(e - r) : longint'(r - e);
            num  = (d * d <= r2) ? r2 - d * d : 0;
            quot = (num << FRAC_W) / r2;
            pair = ubox_held && ((s - held_end) <= ubox_dist);
            if (!emitted) begin
                hit.ppt_start  = s[POS_W-1:0];
                hit.ppt_end    = e[POS_W-1:0];
                hit.score      = quot[SCORE_W-1:0];
                hit.has_ubox   = pair;
                hit.ubox_start = pair ? held_start[POS_W-1:0] : '0;
                hit.ubox_end   = pair ? held_end[POS_W-1:0] : '0;
                hit.strand_tag = reverse_reg;
                expected_hits.push_back(hit);
                emitted = 1'b1;
            end
        end
        drop_ubox();
    endtask

    task automatic predict_state(input logic [1:0] code);
        logic [31:0] r;
        logic [31:0] last_pos;
        logic [31:0] p;
        bit          emitted;
        if (radius_reg == '0)
            r = 32'd1;
        else if (radius_reg > MAX_RADIUS)
            r = MAX_RADIUS;
        else
            r = radius_reg;
        last_pos = 2 * r - 2;
        p        = window_pos;
        emitted  = 1'b0;
        // a lowered radius pulls the position back to the new window end
        if (p > last_pos)
            p = last_pos;
        if (p == 0) begin
            run_start = '0;
        end else if (code != prev_code) begin
            close_run(prev_code, run_start, p - 1, r, emitted);
            run_start = p;
        end
        if (p == last_pos) begin
            close_run(code, run_start, p, r, emitted);
            drop_ubox();
            window_pos = '0;
        end else begin
            window_pos = p + 1;
        end
        prev_code = code;
    endtask

    always @(posedge i_clk) begin
        ppt_hit_t want;
        if (!i_rst_n) begin
            radius_reg  = RST_RADIUS;
            ppt_min     = RST_PPT_LEN_MIN;
            ppt_max     = RST_PPT_LEN_MAX;
            ubox_min    = RST_UBOX_LEN_MIN;
            ubox_max    = RST_UBOX_LEN_MAX;
            ubox_dist   = RST_MAX_UBOX_DIST;
            reverse_reg = 1'b0;
            window_pos  = '0;
            run_start   = '0;
            prev_code   = ST_PPT;
            drop_ubox();
            expected_hits.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                hits++;
                if (i_has_ubox === 1'b1)
                    paired++;
                if (expected_hits.size() == 0) begin
                    $error("hit transfer with no hit predicted: start %0d end %0d",
                           i_ppt_start, i_ppt_end);
                    fails++;
                end else begin
                    want = expected_hits.pop_front();
                    check_field("ppt_start", want.ppt_start, i_ppt_start);
                    check_field("ppt_end", want.ppt_end, i_ppt_end);
                    check_field("score", want.score, i_score);
                    check_field("has_ubox", want.has_ubox, i_has_ubox);
                    check_field("ubox_start", want.ubox_start, i_ubox_start);
                    check_field("ubox_end", want.ubox_end, i_ubox_end);
                    check_field("strand_tag", want.strand_tag, i_strand_tag);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS:        radius_reg  = i_cfg_data;
                    CFG_PPT_LEN_MIN:   ppt_min     = i_cfg_data;
                    CFG_PPT_LEN_MAX:   ppt_max     = i_cfg_data;
                    CFG_UBOX_LEN_MIN:  ubox_min    = i_cfg_data;
                    CFG_UBOX_LEN_MAX:  ubox_max    = i_cfg_data;
                    CFG_MAX_UBOX_DIST: ubox_dist   = i_cfg_data;
                    CFG_REVERSE:       reverse_reg = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predict_state(i_state_code);
        end
        o_pending      <= expected_hits.size();
        o_fail_count   <= fails;
        o_hit_count    <= hits;
        o_paired_count <= paired;
    end

endmodule

// ----- sim/ppt_run_grouper_test.sv -----
// ----------------------------------------------------------------------------
// ppt_run_grouper_test
// drives decoded state streams into the run grouper under a series of register
// settings, with bursty input and a randomly stalling hit receiver
// ----------------------------------------------------------------------------
// A directed opening covers U-box pairing, the window end and a one-position
// window; random phases then send mostly U-box and PPT runs with lengths near
// the accepted limits, plus noise, while the checker predicts every hit.

module ppt_run_grouper_test;
    import prg_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HIT_TARGET   = 48;
    localparam int LONG_HOLD    = 300;
    localparam int LEN_CAP      = 24;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic [1:0]           state_code = ST_BG;
    logic                 out_stall  = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx    = CFG_RADIUS;
    logic [REG_W-1:0]     cfg_data   = '0;

    logic                 in_stall;
    logic                 out_valid;
    logic [POS_W-1:0]     ppt_start;
    logic [POS_W-1:0]     ppt_end;
    logic [SCORE_W-1:0]   score;
    logic                 has_ubox;
    logic [POS_W-1:0]     ubox_start;
    logic [POS_W-1:0]     ubox_end;
    logic                 strand_tag;

    int fail_count;
    int pending_hits;
    int hit_count;
    int paired_count;

    int items_sent       = 0;
    int settings_applied = 0;
    int cycles           = 0;
    int burst_left       = 0;
    int hold_left        = 0;
    int pattern_left     = 0;
    bit long_hold_done   = 1'b0;
    int ppt_lo;
    int ppt_hi;
    int ubox_lo;
    int ubox_hi;

    // three windows of seven positions at radius four
    logic [1:0] directed_states [0:20] = '{
        ST_UBOX, ST_UBOX, ST_PPT, ST_PPT, ST_PPT, ST_BG, ST_BG,
        ST_PPT, ST_PPT, ST_BG, ST_PPT, ST_PPT, ST_PPT, ST_PPT,
        ST_UBOX, ST_UNK, ST_UBOX, ST_UBOX, ST_PPT, ST_PPT, ST_PPT
    };

    ppt_run_grouper dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_state_code (state_code),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_ppt_start  (ppt_start),
        .o_ppt_end    (ppt_end),
        .o_score      (score),
        .o_has_ubox   (has_ubox),
        .o_ubox_start (ubox_start),
        .o_ubox_end   (ubox_end),
        .o_strand_tag (strand_tag),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data)
    );

    ppt_hit_checker hit_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_state_code   (state_code),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_ppt_start    (ppt_start),
        .i_ppt_end      (ppt_end),
        .i_score        (score),
        .i_has_ubox     (has_ubox),
        .i_ubox_start   (ubox_start),
        .i_ubox_end     (ubox_end),
        .i_strand_tag   (strand_tag),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_hits),
        .o_hit_count    (hit_count),
        .o_paired_count (paired_count)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $error("run exceeded %0d cycles", CYCLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // hit receiver: one long hold once hits flow, then short random stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (!long_hold_done && hit_count >= 4) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            out_stall      <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (pattern_left != 0) begin
            pattern_left <= pattern_left - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    out_stall    <= 1'b1;
                    pattern_left <= $urandom_range(0, 5);
                end
                9: begin
                    out_stall    <= 1'b0;
                    pattern_left <= 50;
                end
                default: begin
                    out_stall    <= 1'b0;
                    pattern_left <= $urandom_range(0, 10);
                end
            endcase
        end
    end

    task automatic send_state(input logic [1:0] code);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20);
        end
        burst_left--;
        in_valid   <= 1'b1;
        state_code <= code;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_run(input logic [1:0] code, input int count);
        repeat (count) send_state(code);
    endtask

    // lengths cluster on the accepted limits and just outside them
    function automatic int pick_len(input int lo, input int hi);
        int n;
        if (lo > hi)
            return $urandom_range(1, 12);
        if (lo < 1)
            lo = 1;
        if (hi > LEN_CAP)
            hi = LEN_CAP;
        if (hi < lo)
            hi = lo;
        case ($urandom_range(0, 4))
            0:       n = lo - 1;
            1:       n = lo;
            2:       n = hi;
            3:       n = hi + 1;
            default: n = $urandom_range(lo, hi);
        endcase
        return (n < 1) ? 1 : n;
    endfunction

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_hits != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [REG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [REG_W-1:0] rad,
                                  input logic [REG_W-1:0] pmin,
                                  input logic [REG_W-1:0] pmax,
                                  input logic [REG_W-1:0] umin,
                                  input logic [REG_W-1:0] umax,
                                  input logic [REG_W-1:0] gap_max,
                                  input logic rev);
        wait_idle();
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_PPT_LEN_MIN, pmin);
        write_reg(CFG_PPT_LEN_MAX, pmax);
        write_reg(CFG_UBOX_LEN_MIN, umin);
        write_reg(CFG_UBOX_LEN_MAX, umax);
        write_reg(CFG_MAX_UBOX_DIST, gap_max);
        write_reg(CFG_REVERSE, {{(REG_W-1){1'b0}}, rev});
        cfg_we <= 1'b0;
        ppt_lo  = pmin;
        ppt_hi  = pmax;
        ubox_lo = umin;
        ubox_hi = umax;
        settings_applied++;
    endtask

    task automatic send_random(input int count);
        int target;
        int kind;
        target = items_sent + count;
        while (items_sent < target) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                // optional U-box right before the PPT run, then a closing run
                if ($urandom_range(0, 2) != 0)
                    send_run(ST_UBOX, pick_len(ubox_lo, ubox_hi));
                send_run(ST_PPT, pick_len(ppt_lo, ppt_hi));
                send_run($urandom_range(0, 1) ? ST_BG : ST_UNK, $urandom_range(1, 3));
            end else if (kind < 8) begin
                send_run(2'($urandom_range(0, 3)), $urandom_range(1, 8));
            end else begin
                repeat ($urandom_range(1, 6)) send_state(2'($urandom_range(0, 3)));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        apply_settings(11'd4, 11'd2, 11'd3, 11'd1, 11'd2, 11'd1, 1'b1);
        foreach (directed_states[i])
            send_state(directed_states[i]);

        // zero radius behaves as a one-position window
        apply_settings(11'd0, 11'd1, 11'd1, 11'd1, 11'd1, 11'd0, 1'b0);
        send_state(ST_PPT);
        send_state(ST_UBOX);
        send_state(ST_BG);
        send_state(ST_UNK);

        apply_settings(11'd30, 11'd5, 11'd15, 11'd2, 11'd15, 11'd0, 1'b0);
        send_random(80);
        apply_settings(11'd3, 11'd1, 11'd2, 11'd1, 11'd2, 11'd1, 1'b1);
        send_random(60);
        apply_settings(11'd1, 11'd0, 11'd2047, 11'd0, 11'd2047, 11'd2047, 1'b0);
        send_random(40);
        apply_settings(11'd8, 11'd2047, 11'd0, 11'd1, 11'd5, 11'd2, 1'b1);
        send_random(50);
        apply_settings(11'd6, 11'd1, 11'd4, 11'd3, 11'd1, 11'd3, 1'b0);
        send_random(50);
        apply_settings(11'd12, 11'd2, 11'd6, 11'd1, 11'd4, 11'd5, 1'b1);
        send_random(80);
        apply_settings(11'd2047, 11'd2, 11'd20, 11'd1, 11'd10, 11'd2047, 1'b1);
        send_random(80);
        // radius drops while the wide window is still open
        apply_settings(11'd5, 11'd1, 11'd3, 11'd1, 11'd3, 11'd1, 1'b0);
        send_random(60);
        apply_settings(11'd1024, 11'd2, 11'd12, 11'd1, 11'd8, 11'd1, 1'b0);
        send_random(80);
        apply_settings(11'd2, 11'd1, 11'd3, 11'd1, 11'd1, 11'd1, 1'b1);
        send_random(40);
        apply_settings(11'd20, 11'd1, 11'd10, 11'd1, 11'd6, 11'd1, 1'b1);
        send_random(80);
        while (hit_count < HIT_TARGET) begin
            apply_settings(11'd6, 11'd1, 11'd4, 11'd1, 11'd3, 11'd1, 1'b1);
            send_random(60);
        end

        wait_idle();
        $display("run covered %0d state transfers under %0d register settings",
                 items_sent, settings_applied);
        $display("%0d PPT hits compared, %0d of them paired with a U-box",
                 hit_count, paired_count);
        if (fail_count == 0 && pending_hits == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            if (pending_hits != 0)
                $error("%0d predicted hits never arrived", pending_hits);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/prg_pkg.sv
design/prg_score.sv
design/ppt_run_grouper.sv
design/prg_chk.sv
sim/ppt_hit_checker.sv
sim/ppt_run_grouper_test.sv
